// ----- hdl/rpsp_pkg.sv -----
package rpsp_pkg;

  localparam int LEVEL_FRAC_BITS = 16;
  localparam int LEVEL_W = LEVEL_FRAC_BITS + 1;
  localparam logic [LEVEL_W-1:0] LEVEL_FULL = LEVEL_W'(1) << LEVEL_FRAC_BITS;
  localparam int MULT_W = LEVEL_FRAC_BITS + 2;
  localparam int LSUM_W = LEVEL_FRAC_BITS + 2;
  localparam int TICK_W = 16;
  localparam int GAP_W = 12;
  localparam int ISUM_W = TICK_W + 2;
  localparam int SCALE_W = MULT_W + LSUM_W;
  localparam logic [SCALE_W-1:0] SCALE_LIMIT = SCALE_W'(3) << (2 * LEVEL_FRAC_BITS);

  // level times budget, then times multiplier
  localparam int PROD_W = LEVEL_FRAC_BITS + TICK_W;
  localparam int QPROD_W = PROD_W + MULT_W;

  // first divider: rounded width, second divider: overflow rescale
  localparam int DIV1_NW = PROD_W + 2;
  localparam int DIV1_DW = LSUM_W + 1;
  localparam int DIV1_QW = TICK_W + 1;
  localparam int DIV2_NW = 2 * TICK_W;
  localparam int DIV2_DW = ISUM_W;
  localparam int DIV2_QW = TICK_W;

  localparam int LANE_LAT = 3 + DIV1_QW + 1;
  localparam int MERGE_LAT = 2 + DIV2_QW + 1;
  localparam int PIPE_LAT = 2 + LANE_LAT + MERGE_LAT;

  localparam int NUM_LANES = 3;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_ON = 2'd2;

  localparam logic [TICK_W-1:0] PERIOD_RST = 16'd4000;
  localparam logic [GAP_W-1:0] GAP_RST = 12'd10;
  localparam logic [GAP_W-1:0] MIN_ON_RST = 12'd8;

  typedef struct packed {
    logic [LEVEL_W-1:0] red_level;
    logic [LEVEL_W-1:0] green_level;
    logic [LEVEL_W-1:0] blue_level;
    logic [LEVEL_W-1:0] stretch;
  } in_word_t;

  typedef struct packed {
    logic [TICK_W-1:0] red_start;
    logic [TICK_W-1:0] red_end;
    logic [TICK_W-1:0] green_start;
    logic [TICK_W-1:0] green_end;
    logic [TICK_W-1:0] blue_start;
    logic [TICK_W-1:0] blue_end;
    logic [TICK_W-1:0] red_width;
    logic [TICK_W-1:0] green_width;
    logic [TICK_W-1:0] blue_width;
    logic [TICK_W-1:0] period_out;
  } out_word_t;

  // settings shared by lanes and merge
  typedef struct packed {
    logic [TICK_W-1:0] budget;
    logic [GAP_W-1:0]  gap;
    logic [GAP_W-1:0]  min_on;
  } slot_cfg_t;

  function automatic logic [LEVEL_W-1:0] sat_level(input logic [LEVEL_W-1:0] v);
    sat_level = (v > LEVEL_FULL) ? LEVEL_FULL : v;
  endfunction

endpackage

// ----- hdl/rgb_pulse_slot_packer_unit.sv -----
// rgb pulse slot packer: takes one color word (red, green, blue levels and a
// stretch, unsigned q.16, saturated at full scale) and returns the three pwm
// on widths plus their start and end compare ticks, lit channels packed back
// to back with the programmed dead time after each. the budget is
// period - 3*dead time - 1 (zero when not positive). the datapath is a fixed
// pipeline of 44 register stages, the output register included, and a new
// word can be accepted every cycle while the pipeline is not stalled; the
// depth is set by the two bit-per-stage dividers (17 stages in each color
// lane for the rounded width, 16 in the merge for the overflow rescale).
// the pipeline stalls only when the output register is full and not taken
// while a finished word waits behind it. config registers are written through
// the cfg port (index 0 period, 1 gap, 2 min on; index 3 ignored), cfg_ready
// is always high, and the user must write only while the block holds no
// word; the block itself does not enforce this.
module rgb_pulse_slot_packer_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  rpsp_pkg::in_word_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output rpsp_pkg::out_word_t              out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rpsp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rpsp_pkg::TICK_W-1:0]      cfg_data
);

  localparam int N = rpsp_pkg::NUM_LANES;

  // config registers
  logic [rpsp_pkg::TICK_W-1:0] period_r;
  logic [rpsp_pkg::GAP_W-1:0]  gap_r, min_on_r;
  logic [rpsp_pkg::TICK_W+1:0] gap3;
  rpsp_pkg::slot_cfg_t         cfg;

  // pipeline control
  logic [rpsp_pkg::PIPE_LAT:0] pv_r;
  logic                        en;
  logic                        out_valid_r, out_valid_nxt;
  rpsp_pkg::out_word_t         out_data_r;

  // front stages: input word, saturated levels, scale decision
  rpsp_pkg::in_word_t                  in_r;
  logic [N-1:0][rpsp_pkg::LEVEL_W-1:0] lv_b_r, lv_c_r;
  logic [rpsp_pkg::MULT_W-1:0]         mult_b_r, mult_c_r;
  logic [rpsp_pkg::LSUM_W-1:0]         lsum_b_r, lsum_c_r;
  logic                                scale_c_r;
  logic [N-1:0][rpsp_pkg::LEVEL_W-1:0] lv_nxt;
  logic [rpsp_pkg::LEVEL_W-1:0]        s_sat;
  logic [rpsp_pkg::SCALE_W-1:0]        scale_prod;

  logic [N-1:0][rpsp_pkg::TICK_W-1:0] lane_w;
  logic [N-1:0][rpsp_pkg::TICK_W-1:0] fin_w, fin_start, fin_end;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= rpsp_pkg::PERIOD_RST;
      gap_r    <= rpsp_pkg::GAP_RST;
      min_on_r <= rpsp_pkg::MIN_ON_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rpsp_pkg::REG_PERIOD: period_r <= cfg_data;
        rpsp_pkg::REG_GAP:    gap_r    <= cfg_data[rpsp_pkg::GAP_W-1:0];
        rpsp_pkg::REG_MIN_ON: min_on_r <= cfg_data[rpsp_pkg::GAP_W-1:0];
        default: ;
      endcase
    end
  end

  // budget clamps at zero when the gaps eat the whole period
  assign gap3 = (rpsp_pkg::TICK_W + 2)'(gap_r) * (rpsp_pkg::TICK_W + 2)'(3);
  assign cfg.budget = ((rpsp_pkg::TICK_W + 2)'(period_r) > gap3)
                    ? rpsp_pkg::TICK_W'((rpsp_pkg::TICK_W + 2)'(period_r) - gap3 - 1'b1)
                    : '0;
  assign cfg.gap    = gap_r;
  assign cfg.min_on = min_on_r;

  // advance unless a finished word is blocked by a full output register
  assign en       = !(pv_r[rpsp_pkg::PIPE_LAT] && out_valid_r && !out_ready);
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= '0;
    end else if (en) begin
      pv_r <= {pv_r[rpsp_pkg::PIPE_LAT-1:0], in_valid};
    end
  end

  assign lv_nxt[0] = rpsp_pkg::sat_level(in_r.red_level);
  assign lv_nxt[1] = rpsp_pkg::sat_level(in_r.green_level);
  assign lv_nxt[2] = rpsp_pkg::sat_level(in_r.blue_level);
  assign s_sat     = rpsp_pkg::sat_level(in_r.stretch);

  assign scale_prod = rpsp_pkg::SCALE_W'(mult_b_r) * rpsp_pkg::SCALE_W'(lsum_b_r);

  always_ff @(posedge clk) begin
    if (en) begin
      in_r      <= in_data;
      lv_b_r    <= lv_nxt;
      // multiplier is 1 + 2*stretch in q.16
      mult_b_r  <= rpsp_pkg::MULT_W'(rpsp_pkg::LEVEL_FULL) + {s_sat, 1'b0};
      lsum_b_r  <= rpsp_pkg::LSUM_W'(lv_nxt[0]) + rpsp_pkg::LSUM_W'(lv_nxt[1])
                 + rpsp_pkg::LSUM_W'(lv_nxt[2]);
      lv_c_r    <= lv_b_r;
      mult_c_r  <= mult_b_r;
      lsum_c_r  <= lsum_b_r;
      // raw widths would overrun the budget, so share it by level instead
      scale_c_r <= (lsum_b_r != '0) && (scale_prod > rpsp_pkg::SCALE_LIMIT);
    end
  end

  for (genvar c = 0; c < N; c++) begin : g_lane
    rpsp_lane u_lane (
      .clk  (clk),
      .en   (en),
      .cfg  (cfg),
      .lv   (lv_c_r[c]),
      .mult (mult_c_r),
      .lsum (lsum_c_r),
      .scale(scale_c_r),
      .width(lane_w[c])
    );
  end

  rpsp_merge u_merge (
    .clk      (clk),
    .en       (en),
    .cfg      (cfg),
    .width_in (lane_w),
    .width_out(fin_w),
    .start_out(fin_start),
    .end_out  (fin_end)
  );

  // output register
  always_comb begin
    if (pv_r[rpsp_pkg::PIPE_LAT] && en) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pv_r[rpsp_pkg::PIPE_LAT] && en) begin
      out_data_r.red_start   <= fin_start[0];
      out_data_r.red_end     <= fin_end[0];
      out_data_r.green_start <= fin_start[1];
      out_data_r.green_end   <= fin_end[1];
      out_data_r.blue_start  <= fin_start[2];
      out_data_r.blue_end    <= fin_end[2];
      out_data_r.red_width   <= fin_w[0];
      out_data_r.green_width <= fin_w[1];
      out_data_r.blue_width  <= fin_w[2];
      out_data_r.period_out  <= period_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- hdl/rpsp_div.sv -----
module rpsp_div #(
  parameter int NW = rpsp_pkg::DIV1_NW,
  parameter int DW = rpsp_pkg::DIV1_DW,
  parameter int QW = rpsp_pkg::DIV1_QW
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo
);

  // one quotient bit per stage, quotient known to fit in QW bits
  logic [DW-1:0] rem_w [QW+1];
  logic [QW-1:0] low_w [QW+1];
  logic [QW-1:0] q_w   [QW+1];
  logic [DW-1:0] den_w [QW+1];

  assign rem_w[0] = DW'(num >> QW);
  assign low_w[0] = num[QW-1:0];
  assign q_w[0]   = '0;
  assign den_w[0] = den;

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [DW:0]   trial;
    logic          ge;
    logic [DW:0]   diff;
    logic [DW-1:0] rem_r;
    logic [QW-1:0] low_r;
    logic [QW-1:0] q_r;
    logic [DW-1:0] den_r;

    assign trial = {rem_w[i], low_w[i][QW-1]};
    assign ge    = trial >= {1'b0, den_w[i]};
    assign diff  = trial - {1'b0, den_w[i]};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r <= ge ? diff[DW-1:0] : trial[DW-1:0];
        low_r <= low_w[i] << 1;
        q_r   <= {q_w[i][QW-2:0], ge};
        den_r <= den_w[i];
      end
    end

    assign rem_w[i+1] = rem_r;
    assign low_w[i+1] = low_r;
    assign q_w[i+1]   = q_r;
    assign den_w[i+1] = den_r;
  end

  assign quo = q_w[QW];

endmodule

// ----- hdl/rpsp_lane.sv -----
module rpsp_lane (
  input  logic                          clk,
  input  logic                          en,
  input  rpsp_pkg::slot_cfg_t           cfg,
  input  logic [rpsp_pkg::LEVEL_W-1:0]  lv,
  input  logic [rpsp_pkg::MULT_W-1:0]   mult,
  input  logic [rpsp_pkg::LSUM_W-1:0]   lsum,
  input  logic                          scale,
  output logic [rpsp_pkg::TICK_W-1:0]   width
);

  logic [rpsp_pkg::PROD_W-1:0]  p_r, p2_r;
  logic [rpsp_pkg::MULT_W-1:0]  mult1_r;
  logic [rpsp_pkg::LSUM_W-1:0]  lsum1_r, lsum2_r;
  logic                         scale1_r, scale2_r;
  logic [rpsp_pkg::QPROD_W-1:0] q_r;
  logic [rpsp_pkg::DIV1_NW-1:0] num_r, num_nxt;
  logic [rpsp_pkg::DIV1_DW-1:0] den_r, den_nxt;
  logic [rpsp_pkg::PROD_W:0]    p_nxt;
  logic [rpsp_pkg::QPROD_W:0]   z_sum;
  logic [rpsp_pkg::DIV1_QW-1:0] quo;
  logic [rpsp_pkg::TICK_W-1:0]  clamp;
  logic [rpsp_pkg::TICK_W-1:0]  width_r, width_nxt;

  assign p_nxt = (rpsp_pkg::PROD_W + 1)'(lv) * (rpsp_pkg::PROD_W + 1)'(cfg.budget);

  // unscaled path: round(q / (3 F^2)) as floor(((q + 3 F^2 / 2) >> 2F) / 3)
  assign z_sum = (rpsp_pkg::QPROD_W + 1)'(q_r)
               + ((rpsp_pkg::QPROD_W + 1)'(3) << (2 * rpsp_pkg::LEVEL_FRAC_BITS - 1));

  always_comb begin
    if (scale2_r) begin
      num_nxt = rpsp_pkg::DIV1_NW'({p2_r, 1'b0}) + rpsp_pkg::DIV1_NW'(lsum2_r);
      den_nxt = {lsum2_r, 1'b0};
    end else begin
      num_nxt = rpsp_pkg::DIV1_NW'(z_sum >> (2 * rpsp_pkg::LEVEL_FRAC_BITS));
      den_nxt = rpsp_pkg::DIV1_DW'(3);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r      <= p_nxt[rpsp_pkg::PROD_W-1:0];
      mult1_r  <= mult;
      lsum1_r  <= lsum;
      scale1_r <= scale;
      q_r      <= rpsp_pkg::QPROD_W'(p_r) * rpsp_pkg::QPROD_W'(mult1_r);
      p2_r     <= p_r;
      lsum2_r  <= lsum1_r;
      scale2_r <= scale1_r;
      num_r    <= num_nxt;
      den_r    <= den_nxt;
      width_r  <= width_nxt;
    end
  end

  rpsp_div #(
    .NW(rpsp_pkg::DIV1_NW),
    .DW(rpsp_pkg::DIV1_DW),
    .QW(rpsp_pkg::DIV1_QW)
  ) u_div (
    .clk(clk),
    .en (en),
    .num(num_r),
    .den(den_r),
    .quo(quo)
  );

  // clamp to budget, then lift small lit widths to the minimum
  assign clamp = (quo > rpsp_pkg::DIV1_QW'(cfg.budget)) ? cfg.budget
                                                        : quo[rpsp_pkg::TICK_W-1:0];
  assign width_nxt = (clamp != '0 && clamp < rpsp_pkg::TICK_W'(cfg.min_on))
                   ? rpsp_pkg::TICK_W'(cfg.min_on) : clamp;

  assign width = width_r;

endmodule

// ----- hdl/rpsp_merge.sv -----
module rpsp_merge (
  input  logic                                              clk,
  input  logic                                              en,
  input  rpsp_pkg::slot_cfg_t                               cfg,
  input  logic [rpsp_pkg::NUM_LANES-1:0][rpsp_pkg::TICK_W-1:0] width_in,
  output logic [rpsp_pkg::NUM_LANES-1:0][rpsp_pkg::TICK_W-1:0] width_out,
  output logic [rpsp_pkg::NUM_LANES-1:0][rpsp_pkg::TICK_W-1:0] start_out,
  output logic [rpsp_pkg::NUM_LANES-1:0][rpsp_pkg::TICK_W-1:0] end_out
);

  localparam int N = rpsp_pkg::NUM_LANES;
  localparam int QW = rpsp_pkg::DIV2_QW;

  logic [rpsp_pkg::ISUM_W-1:0]  isum_nxt, isum_r;
  logic                         over_r;
  logic [N-1:0][rpsp_pkg::TICK_W-1:0] w1_r, wf_r;
  logic [rpsp_pkg::ISUM_W-1:0]  den_r;
  logic [N-1:0][rpsp_pkg::DIV2_NW-1:0] num_r;
  logic [N-1:0][rpsp_pkg::DIV2_QW-1:0] quo;
  logic [N-1:0][rpsp_pkg::TICK_W-1:0] dly_w_r [QW+1];
  logic                               dly_over_r [QW+1];

  always_comb begin
    isum_nxt = '0;
    for (int c = 0; c < N; c++) begin
      isum_nxt = isum_nxt + rpsp_pkg::ISUM_W'(width_in[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      isum_r        <= isum_nxt;
      w1_r          <= width_in;
      over_r        <= isum_nxt > rpsp_pkg::ISUM_W'(cfg.budget);
      den_r         <= isum_r;
      dly_w_r[0]    <= w1_r;
      dly_over_r[0] <= over_r;
      for (int c = 0; c < N; c++) begin
        num_r[c] <= rpsp_pkg::DIV2_NW'(w1_r[c]) * rpsp_pkg::DIV2_NW'(cfg.budget);
      end
      for (int k = 0; k < QW; k++) begin
        dly_w_r[k+1]    <= dly_w_r[k];
        dly_over_r[k+1] <= dly_over_r[k];
      end
      for (int c = 0; c < N; c++) begin
        wf_r[c] <= (dly_over_r[QW] && dly_w_r[QW][c] != '0) ? quo[c] : dly_w_r[QW][c];
      end
    end
  end

  for (genvar c = 0; c < N; c++) begin : g_div
    rpsp_div #(
      .NW(rpsp_pkg::DIV2_NW),
      .DW(rpsp_pkg::DIV2_DW),
      .QW(rpsp_pkg::DIV2_QW)
    ) u_div (
      .clk(clk),
      .en (en),
      .num(num_r[c]),
      .den(den_r),
      .quo(quo[c])
    );
  end

  // pack lit channels back to back, dark ones take no slot
  always_comb begin
    logic [rpsp_pkg::TICK_W-1:0] acc;
    acc = '0;
    for (int c = 0; c < N; c++) begin
      if (wf_r[c] != '0) begin
        start_out[c] = acc;
        end_out[c]   = acc + wf_r[c];
        acc          = acc + wf_r[c] + rpsp_pkg::TICK_W'(cfg.gap);
      end else begin
        start_out[c] = '0;
        end_out[c]   = '0;
      end
    end
  end

  assign width_out = wf_r;

endmodule

// ----- hdl/rpsp_checker.sv -----
module rpsp_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_ready,
  input rpsp_pkg::out_word_t            out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("output word changed while stalled");

  a_red_span: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.red_width != '0 |->
      out_data.red_end == out_data.red_start + out_data.red_width)
    else $error("red end does not match start plus width");

  a_dark_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.blue_width == '0 |->
      out_data.blue_start == '0 && out_data.blue_end == '0)
    else $error("dark blue channel has nonzero compares");

endmodule

bind rgb_pulse_slot_packer_unit rpsp_checker u_rpsp_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);

// ----- tb/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // index past the register list, the block must drop it
  localparam logic [rpsp_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = rpsp_pkg::PIPE_LAT + 20;
  localparam int CYCLE_LIMIT = 600000;
  localparam int NUM_FIELDS = 10;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  rpsp_pkg::in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  rpsp_pkg::out_word_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [rpsp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [rpsp_pkg::TICK_W-1:0] cfg_data = '0;

  rgb_pulse_slot_packer_unit i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow copy of the timing registers
  logic [rpsp_pkg::TICK_W-1:0] period_reg = rpsp_pkg::PERIOD_RST;
  logic [rpsp_pkg::GAP_W-1:0] gap_reg = rpsp_pkg::GAP_RST;
  logic [rpsp_pkg::GAP_W-1:0] min_on_reg = rpsp_pkg::MIN_ON_RST;

  rpsp_pkg::out_word_t slot_q[$];     // predicted words in send order
  int mismatches = 0;
  int cycles = 0;
  int burst_left = 0;
  bit steady_send = 0;      // phase without sender gaps
  string field_name[NUM_FIELDS] = '{"red_start", "red_end", "green_start", "green_end",
    "blue_start", "blue_end", "red_width", "green_width", "blue_width", "period_out"};

  // exact integer version of the slot packing
  function automatic rpsp_pkg::out_word_t predict_slots(rpsp_pkg::in_word_t w);
    longint unsigned full, lv[3], wd[3], s, mult, lsum, budget, isum, acc, den;
    longint b;
    logic [rpsp_pkg::LEVEL_W-1:0] raw[3];
    logic [rpsp_pkg::TICK_W-1:0] fld[NUM_FIELDS];
    rpsp_pkg::out_word_t r;
    full = longint'(1) << rpsp_pkg::LEVEL_FRAC_BITS;
    raw[0] = w.red_level;
    raw[1] = w.green_level;
    raw[2] = w.blue_level;
    b = longint'(period_reg) - 3 * longint'(gap_reg) - 1;
    budget = (b > 0) ? b : 0;
    for (int c = 0; c < 3; c++) lv[c] = (raw[c] > full) ? full : raw[c];
    s = (w.stretch > full) ? full : w.stretch;
    mult = full + 2 * s;
    lsum = lv[0] + lv[1] + lv[2];
    for (int c = 0; c < 3; c++) begin
      if (budget == 0) begin
        wd[c] = 0;
      end else if (lsum > 0 && mult * lsum > 3 * full * full) begin
        // over budget: share it in proportion to level, rounded half up
        wd[c] = (2 * lv[c] * budget + lsum) / (2 * lsum);
      end else begin
        den = 3 * full * full;
        wd[c] = (2 * lv[c] * budget * mult + den) / (2 * den);
      end
      if (wd[c] > budget) wd[c] = budget;
      if (wd[c] > 0 && wd[c] < min_on_reg) wd[c] = min_on_reg;
    end
    isum = wd[0] + wd[1] + wd[2];
    if (isum > budget)
      for (int c = 0; c < 3; c++) if (wd[c] > 0) wd[c] = wd[c] * budget / isum;
    acc = 0;
    for (int c = 0; c < 3; c++) begin
      if (wd[c] > 0) begin
        fld[2*c] = acc[rpsp_pkg::TICK_W-1:0];
        fld[2*c+1] = rpsp_pkg::TICK_W'(acc + wd[c]);
        acc += wd[c] + gap_reg;
      end else begin
        fld[2*c] = '0;
        fld[2*c+1] = '0;
      end
      fld[6+c] = wd[c][rpsp_pkg::TICK_W-1:0];
    end
    fld[9] = period_reg;
    for (int k = 0; k < NUM_FIELDS; k++)
      r[(NUM_FIELDS-1-k)*rpsp_pkg::TICK_W +: rpsp_pkg::TICK_W] = fld[k];
    return r;
  endfunction

  // cycle count and timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** rgb_pulse_slot_packer_unit: FAILED **");
      $finish;
    end
  end

  // receiver: stall pattern steps through four phases as the cycle count runs
  always @(posedge clk) begin
    case ((cycles >> 8) % 4)
      0: begin
        out_ready <= 1'b1;
      end
      1: begin
        out_ready <= (cycles % 7) > 2;
      end
      2: begin
        out_ready <= ($urandom_range(0, 99) < 65);
      end
      default: begin
        out_ready <= ($urandom_range(0, 99) < 20);
      end
    endcase
  end

  // result check against the oldest prediction
  always @(posedge clk) begin
    rpsp_pkg::out_word_t exp_w;
    bit bad;
    if (rst_n && out_valid && out_ready) begin
      if (slot_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", out_data);
      end else begin
        exp_w = slot_q.pop_front();
        bad = 0;
        for (int k = 0; k < NUM_FIELDS; k++) begin
          if (out_data[(NUM_FIELDS-1-k)*rpsp_pkg::TICK_W +: rpsp_pkg::TICK_W] !==
              exp_w[(NUM_FIELDS-1-k)*rpsp_pkg::TICK_W +: rpsp_pkg::TICK_W]) begin
            bad = 1;
            if (mismatches < 10)
              $display("%s: expected %0d got %0d", field_name[k],
                       exp_w[(NUM_FIELDS-1-k)*rpsp_pkg::TICK_W +: rpsp_pkg::TICK_W],
                       out_data[(NUM_FIELDS-1-k)*rpsp_pkg::TICK_W +: rpsp_pkg::TICK_W]);
          end
        end
        if (bad) mismatches++;
      end
    end
  end

  task automatic write_reg(input logic [rpsp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rpsp_pkg::TICK_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      rpsp_pkg::REG_PERIOD: period_reg = val;
      rpsp_pkg::REG_GAP: gap_reg = val[rpsp_pkg::GAP_W-1:0];
      rpsp_pkg::REG_MIN_ON: min_on_reg = val[rpsp_pkg::GAP_W-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // block must hold no word before a register write
  task automatic drain;
    in_valid <= 1'b0;
    while (slot_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_timing(input int per, input int gap, input int min_on);
    drain();
    write_reg(rpsp_pkg::REG_PERIOD, rpsp_pkg::TICK_W'(per));
    write_reg(rpsp_pkg::REG_GAP, rpsp_pkg::TICK_W'(gap));
    write_reg(rpsp_pkg::REG_MIN_ON, rpsp_pkg::TICK_W'(min_on));
  endtask

  // one color word, with sender bursts and gaps
  task automatic send_word(input rpsp_pkg::in_word_t w);
    int g;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      g = steady_send ? 0 : $urandom_range(0, 6);
      if (g > 0) begin
        in_valid <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
    burst_left--;
    slot_q.push_back(predict_slots(w));
    in_data <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic logic [rpsp_pkg::LEVEL_W-1:0] pick_level();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return rpsp_pkg::LEVEL_FULL;
      2: return rpsp_pkg::LEVEL_W'($urandom_range(rpsp_pkg::LEVEL_FULL + 1,
                                                  (1 << rpsp_pkg::LEVEL_W) - 1));
      3: return rpsp_pkg::LEVEL_W'($urandom_range(0, 255));
      4: return rpsp_pkg::LEVEL_W'($urandom_range(0, (1 << rpsp_pkg::LEVEL_W) - 1));
      default: return rpsp_pkg::LEVEL_W'($urandom_range(0, rpsp_pkg::LEVEL_FULL));
    endcase
  endfunction

  function automatic rpsp_pkg::in_word_t pick_word();
    rpsp_pkg::in_word_t w;
    w.red_level = pick_level();
    w.green_level = pick_level();
    w.blue_level = pick_level();
    w.stretch = pick_level();
    return w;
  endfunction

  task automatic send_levels(input int r, input int g, input int b, input int s);
    rpsp_pkg::in_word_t w;
    w.red_level = rpsp_pkg::LEVEL_W'(r);
    w.green_level = rpsp_pkg::LEVEL_W'(g);
    w.blue_level = rpsp_pkg::LEVEL_W'(b);
    w.stretch = rpsp_pkg::LEVEL_W'(s);
    send_word(w);
  endtask

  // extremes, saturation, all off, single channels, min snap
  task automatic test_directed;
    steady_send = 1;
    send_levels(0, 0, 0, 0);
    send_levels(rpsp_pkg::LEVEL_FULL, rpsp_pkg::LEVEL_FULL, rpsp_pkg::LEVEL_FULL,
                rpsp_pkg::LEVEL_FULL);
    send_levels('1, '1, '1, '1);
    send_levels(rpsp_pkg::LEVEL_FULL + 1, 0, 0, 0);
    send_levels(0, rpsp_pkg::LEVEL_FULL, 0, 0);
    send_levels(0, 0, rpsp_pkg::LEVEL_FULL, rpsp_pkg::LEVEL_FULL);
    send_levels(1, 1, 1, 0);
    send_levels(rpsp_pkg::LEVEL_FULL / 2, 0, rpsp_pkg::LEVEL_FULL / 4,
                rpsp_pkg::LEVEL_FULL / 2);
    send_levels(rpsp_pkg::LEVEL_FULL, 1, 0, rpsp_pkg::LEVEL_FULL);
    send_levels(12345, 54321, 777, 65535);
    send_levels('h15555, 'h0aaaa, 'h1ffff, 'h0aaaa);
    send_levels('h0aaaa, 'h15555, 'h00001, 'h15555);
  endtask

  // budget zero or negative, tiny budget with big min on, widest period
  task automatic test_budget_edges;
    set_timing(8, 10, 8);
    send_levels(rpsp_pkg::LEVEL_FULL, rpsp_pkg::LEVEL_FULL, rpsp_pkg::LEVEL_FULL, 0);
    send_levels(100, 0, 200, 300);
    set_timing(8, 2, 0);         // budget of exactly one tick
    send_levels(rpsp_pkg::LEVEL_FULL, rpsp_pkg::LEVEL_FULL, rpsp_pkg::LEVEL_FULL,
                rpsp_pkg::LEVEL_FULL);
    send_levels(rpsp_pkg::LEVEL_FULL, 0, 0, 0);
    set_timing(40, 0, 4095);     // min on forces the rescale
    send_levels(10, 20, 30, 0);
    send_levels(rpsp_pkg::LEVEL_FULL, 5, 0, 0);
    set_timing(65535, 0, 0);
    send_levels(rpsp_pkg::LEVEL_FULL, rpsp_pkg::LEVEL_FULL, rpsp_pkg::LEVEL_FULL,
                rpsp_pkg::LEVEL_FULL);
    send_levels(1, 0, 0, 0);
    send_levels(3, 2, 1, 0);
    // gap and min on masked to 12 bits, out of range index dropped
    drain();
    write_reg(rpsp_pkg::REG_GAP, 16'hf00c);
    write_reg(rpsp_pkg::REG_MIN_ON, 16'hffff);
    write_reg(REG_UNUSED, 16'h1234);
    send_levels(rpsp_pkg::LEVEL_FULL, rpsp_pkg::LEVEL_FULL / 3, 9, rpsp_pkg::LEVEL_FULL / 3);
    send_levels(40000, 30000, 20000, 0);
  endtask

  // random words over a series of timing settings
  task automatic test_random;
    int per, gap, min_on;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin per = 4000; gap = 10; min_on = 8; end
        1: begin per = 65535; gap = 4095; min_on = 4095; end
        2: begin per = 65535; gap = 0; min_on = 0; end
        3: begin per = 200; gap = 3; min_on = 60; end
        4: begin per = 8; gap = 0; min_on = 1; end
        default: begin
          per = $urandom_range(8, 65535);
          gap = $urandom_range(0, 4095);
          min_on = $urandom_range(0, 4095);
          if ($urandom_range(0, 1)) gap = $urandom_range(0, per / 8);
        end
      endcase
      set_timing(per, gap, min_on);
      steady_send = (ph % 3 == 2);
      repeat (190) send_word(pick_word());
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_budget_edges();
    test_random();
    drain();
    if (mismatches == 0)
      $display("** rgb_pulse_slot_packer_unit: PASSED **");
    else
      $display("** rgb_pulse_slot_packer_unit: FAILED **");
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/rpsp_pkg.sv
hdl/rpsp_div.sv
hdl/rpsp_lane.sv
hdl/rpsp_merge.sv
hdl/rgb_pulse_slot_packer_unit.sv
hdl/rpsp_checker.sv
tb/testbench.sv
